FILE: src/hdb_pkg.sv
// Shared types and constants for the HDLC bit deframer.
// Used by hdb_step, hdlc_bit_deframer_unit, hdb_port_checks, hdb_checker and testbench; depends on nothing.
`default_nettype none

package hdb_pkg;

	// Length counters and length registers
	localparam int LEN_W       = 10;
	localparam int LEN_LIMIT   = 1023;
	localparam int CNT_W       = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = LEN_W;

	// Register reset values
	localparam logic [LEN_W-1:0] MIN_LEN_RST = LEN_W'(17);
	localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(330);

	// Line constants
	localparam logic [7:0] FLAG_PATTERN = 8'h7E;
	localparam logic [2:0] ONES_ABORT   = 3'd7;
	localparam logic [2:0] ONES_STUFF   = 3'd5;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		MODE_HUNT = 2'd0,
		MODE_SYNC = 2'd1,
		MODE_DATA = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		EV_DATA       = 3'd0,
		EV_GOOD       = 3'd1,
		EV_SHORT      = 3'd2,
		EV_ONES_ABORT = 3'd3,
		EV_OVF_ABORT  = 3'd4
	} event_t;

	// Decoder state carried from one line bit to the next
	typedef struct packed {
		logic [7:0]       raw_window;
		logic [7:0]       data_shift;
		logic [3:0]       bit_counter;
		logic [2:0]       ones_run;
		mode_t            rx_mode;
		logic [LEN_W-1:0] byte_counter;
		logic [CNT_W-1:0] good_frames;
		logic [CNT_W-1:0] aborts_seen;
	} dec_state_t;

	// One result item, with a flag telling whether the bit produced one
	typedef struct packed {
		logic             emit;
		event_t           ev;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] frame_length;
		logic [CNT_W-1:0] good_frames;
		logic [CNT_W-1:0] aborts_seen;
	} dec_result_t;

endpackage

`default_nettype wire

FILE: src/hdlc_bit_deframer_unit.sv
// Top level of the HDLC bit deframer: input register, decoder state, result register.
// Depends on hdb_pkg and hdb_step.
`default_nettype none

// Takes one NRZI-decoded line bit per item, least significant bit first, and
// gives at most one result item per bit: a data byte, a frame end (good or too
// short) or an abort. One item can be accepted every cycle while in_stall is low.
// The bit is captured in the input register when accepted; its result, if any,
// is loaded into the result register when the input register advances. The
// decoder state is updated by combinational logic behind the input register, so
// the rate is set only by output stall: while a result waits with out_stall
// high and the input register is full, in_stall is raised.
module hdlc_bit_deframer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           rx_bit,
	input  wire logic                           restart,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [2:0]                          event_res,
	output logic [7:0]                          data_byte,
	output logic [hdb_pkg::LEN_W-1:0]           frame_length,
	output logic [hdb_pkg::CNT_W-1:0]           good_frame_count,
	output logic [hdb_pkg::CNT_W-1:0]           abort_count,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [hdb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hdb_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                        valid_s1;
	logic                        rx_bit_s1;
	logic                        restart_s1;
	logic                        advance;
	logic [hdb_pkg::LEN_W-1:0]   min_len_q;
	logic [hdb_pkg::LEN_W-1:0]   max_len_q;
	hdb_pkg::dec_state_t         state_q;
	hdb_pkg::dec_state_t         state_nxt;
	hdb_pkg::dec_result_t        res;
	logic                        out_valid_q;
	hdb_pkg::dec_result_t        out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= hdb_pkg::MIN_LEN_RST;
			max_len_q <= hdb_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hdb_pkg::REG_MIN_LEN: min_len_q <= cfg_data;
				hdb_pkg::REG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_bit_s1  <= rx_bit;
			restart_s1 <= restart;
		end
	end

	hdb_step u_step (
		.min_frame_len (min_len_q),
		.max_frame_len (max_len_q),
		.cur           (state_q),
		.rx_bit        (rx_bit_s1),
		.restart       (restart_s1),
		.nxt           (state_nxt),
		.res           (res)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.raw_window   <= 8'd0;
			state_q.data_shift   <= 8'd0;
			state_q.bit_counter  <= 4'd0;
			state_q.ones_run     <= 3'd0;
			state_q.rx_mode      <= hdb_pkg::MODE_HUNT;
			state_q.byte_counter <= '0;
			state_q.good_frames  <= '0;
			state_q.aborts_seen  <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res.emit) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign event_res        = out_q.ev;
	assign data_byte        = out_q.data_byte;
	assign frame_length     = out_q.frame_length;
	assign good_frame_count = out_q.good_frames;
	assign abort_count      = out_q.aborts_seen;

endmodule

`default_nettype wire

FILE: src/hdb_step.sv
// Next-state and result logic of the deframer for one line bit.
// Depends on hdb_pkg.
`default_nettype none

module hdb_step (
	input  wire logic [hdb_pkg::LEN_W-1:0] min_frame_len,
	input  wire logic [hdb_pkg::LEN_W-1:0] max_frame_len,
	input  wire hdb_pkg::dec_state_t       cur,
	input  wire logic                      rx_bit,
	input  wire logic                      restart,
	output hdb_pkg::dec_state_t            nxt,
	output hdb_pkg::dec_result_t           res
);

	logic [7:0]                 raw_n;
	logic [2:0]                 ones_n;
	logic [3:0]                 bits_n;
	logic [7:0]                 data_n;
	logic [15:0]                limit;
	logic [hdb_pkg::LEN_W-1:0]  len_p1;

	// Effective maximum length, capped at the hard limit
	always_comb begin
		if (16'(max_frame_len) > 16'(hdb_pkg::LEN_LIMIT)) begin
			limit = 16'(hdb_pkg::LEN_LIMIT);
		end else begin
			limit = 16'(max_frame_len);
		end
	end

	assign raw_n  = {rx_bit, cur.raw_window[7:1]};
	assign data_n = {rx_bit, cur.data_shift[7:1]};
	assign bits_n = cur.bit_counter + 4'd1;
	assign len_p1 = cur.byte_counter + hdb_pkg::LEN_W'(1);

	// Ones run saturates at seven
	always_comb begin
		if (!rx_bit) begin
			ones_n = 3'd0;
		end else if (cur.ones_run == hdb_pkg::ONES_ABORT) begin
			ones_n = hdb_pkg::ONES_ABORT;
		end else begin
			ones_n = cur.ones_run + 3'd1;
		end
	end

	// Priority: restart, flag, seven ones, hunt, stuffed zero, data bit
	always_comb begin
		nxt              = cur;
		res.emit         = 1'b0;
		res.ev           = hdb_pkg::EV_DATA;
		res.data_byte    = 8'd0;
		res.frame_length = cur.byte_counter;

		if (restart) begin
			nxt.raw_window   = 8'd0;
			nxt.ones_run     = 3'd0;
			nxt.rx_mode      = hdb_pkg::MODE_HUNT;
			nxt.byte_counter = '0;
			nxt.bit_counter  = 4'd0;
			nxt.data_shift   = 8'd0;
		end else begin
			nxt.raw_window = raw_n;
			nxt.ones_run   = ones_n;
			if (raw_n == hdb_pkg::FLAG_PATTERN) begin
				nxt.rx_mode      = hdb_pkg::MODE_SYNC;
				nxt.byte_counter = '0;
				nxt.bit_counter  = 4'd0;
				nxt.data_shift   = 8'd0;
				if (cur.rx_mode == hdb_pkg::MODE_DATA) begin
					res.emit = 1'b1;
					if (cur.byte_counter >= min_frame_len) begin
						res.ev          = hdb_pkg::EV_GOOD;
						nxt.good_frames = cur.good_frames + hdb_pkg::CNT_W'(1);
					end else begin
						res.ev = hdb_pkg::EV_SHORT;
					end
				end
			end else if (ones_n == hdb_pkg::ONES_ABORT &&
				cur.rx_mode != hdb_pkg::MODE_HUNT) begin
				nxt.rx_mode      = hdb_pkg::MODE_HUNT;
				nxt.byte_counter = '0;
				nxt.bit_counter  = 4'd0;
				nxt.data_shift   = 8'd0;
				if (cur.rx_mode == hdb_pkg::MODE_DATA) begin
					res.emit        = 1'b1;
					res.ev          = hdb_pkg::EV_ONES_ABORT;
					nxt.aborts_seen = cur.aborts_seen + hdb_pkg::CNT_W'(1);
				end
			end else if (cur.rx_mode == hdb_pkg::MODE_HUNT) begin
				// hunting: only the window and ones run move
			end else if (!rx_bit && cur.ones_run == hdb_pkg::ONES_STUFF) begin
				// stuffed zero dropped
			end else begin
				nxt.data_shift = data_n;
				if (bits_n < hdb_pkg::BITS_PER_BYTE) begin
					nxt.bit_counter = bits_n;
				end else if (16'(cur.byte_counter) >= limit) begin
					nxt.rx_mode      = hdb_pkg::MODE_HUNT;
					nxt.byte_counter = '0;
					nxt.bit_counter  = 4'd0;
					nxt.data_shift   = 8'd0;
					nxt.aborts_seen  = cur.aborts_seen + hdb_pkg::CNT_W'(1);
					res.emit         = 1'b1;
					res.ev           = hdb_pkg::EV_OVF_ABORT;
				end else begin
					nxt.bit_counter  = 4'd0;
					nxt.byte_counter = len_p1;
					nxt.rx_mode      = hdb_pkg::MODE_DATA;
					res.emit         = 1'b1;
					res.ev           = hdb_pkg::EV_DATA;
					res.data_byte    = data_n;
					res.frame_length = len_p1;
				end
			end
		end

		// Counters as they stand after this bit
		res.good_frames = nxt.good_frames;
		res.aborts_seen = nxt.aborts_seen;
	end

endmodule

`default_nettype wire

FILE: src/hdb_checker.sv
// Port-level checks for hdlc_bit_deframer_unit, with the bind that attaches them.
// Depends on hdb_pkg and hdlc_bit_deframer_unit.
`default_nettype none

module hdb_port_checks (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [2:0]                   event_res,
	input wire logic [7:0]                   data_byte,
	input wire logic [hdb_pkg::LEN_W-1:0]    frame_length
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) &&
		$stable(data_byte) && $stable(frame_length))
		else $error("stalled result changed");

	// Input backs up only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no result waiting");

	// Only the five event codes appear
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res <= 3'(hdb_pkg::EV_OVF_ABORT))
		else $error("event code out of range");

	// Frame ends and aborts carry no byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != 3'(hdb_pkg::EV_DATA) |-> data_byte == 8'd0)
		else $error("byte on a non-data event");

	// A data byte always counts at least one byte in the frame
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == 3'(hdb_pkg::EV_DATA) |-> frame_length != '0)
		else $error("data byte with zero frame length");

endmodule

bind hdlc_bit_deframer_unit hdb_port_checks u_hdb_port_checks (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.event_res    (event_res),
	.data_byte    (data_byte),
	.frame_length (frame_length)
);

`default_nettype wire

FILE: verif/hdb_checker.sv
// Checker for the HDLC bit deframer: watches the line-bit and result channels,
// predicts every result item and compares it field by field. Depends on hdb_pkg.
`default_nettype none

module hdb_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic                           rx_bit,
	input  wire logic                           restart,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic [2:0]                     event_res,
	input  wire logic [7:0]                     data_byte,
	input  wire logic [hdb_pkg::LEN_W-1:0]      frame_length,
	input  wire logic [hdb_pkg::CNT_W-1:0]      good_frame_count,
	input  wire logic [hdb_pkg::CNT_W-1:0]      abort_count,
	input  wire logic                           cfg_we,
	input  wire logic [hdb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hdb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  results_seen
);
	import hdb_pkg::*;

	// Predicted decoder state and length settings
	logic [7:0]       line_window;
	logic [7:0]       byte_shift;
	logic [3:0]       bit_pos;
	logic [2:0]       ones_len;
	mode_t            mode;
	logic [LEN_W-1:0] byte_cnt;
	logic [CNT_W-1:0] good_cnt;
	logic [CNT_W-1:0] abort_cnt;
	logic [LEN_W-1:0] min_len;
	logic [LEN_W-1:0] max_len;

	dec_result_t expected_events[$];

	function automatic void drop_frame(mode_t next_mode);
		mode = next_mode;
		byte_cnt = '0;
		bit_pos = '0;
		byte_shift = '0;
	endfunction

	function automatic void post_event(event_t ev, logic [7:0] d, logic [LEN_W-1:0] len);
		dec_result_t r;
		r.emit = 1'b1;
		r.ev = ev;
		r.data_byte = d;
		r.frame_length = len;
		r.good_frames = good_cnt;
		r.aborts_seen = abort_cnt;
		expected_events.push_back(r);
	endfunction

	function automatic void check_field(string what, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// One line bit through the deframer; queues the result it causes, if any
	task automatic deframe_bit(input logic b, input logic rs);
		logic [2:0]       prev_ones;
		logic [LEN_W-1:0] cap;
		logic [LEN_W-1:0] len;
		mode_t            was;
		if (rs) begin
			line_window = '0;
			ones_len = '0;
			drop_frame(MODE_HUNT);
		end else begin
			line_window = {b, line_window[7:1]};
			prev_ones = ones_len;
			if (b)
				ones_len = (ones_len == ONES_ABORT) ? ONES_ABORT : ones_len + 3'd1;
			else
				ones_len = '0;

			if (line_window == FLAG_PATTERN) begin
				// flag: closes a frame that holds data, otherwise just syncs
				was = mode;
				len = byte_cnt;
				drop_frame(MODE_SYNC);
				if (was == MODE_DATA) begin
					if (len >= min_len) begin
						good_cnt++;
						post_event(EV_GOOD, 8'h00, len);
					end else begin
						post_event(EV_SHORT, 8'h00, len);
					end
				end
			end else if (ones_len == ONES_ABORT && mode != MODE_HUNT) begin
				was = mode;
				len = byte_cnt;
				drop_frame(MODE_HUNT);
				if (was == MODE_DATA) begin
					abort_cnt++;
					post_event(EV_ONES_ABORT, 8'h00, len);
				end
			end else if (mode != MODE_HUNT && !(b == 1'b0 && prev_ones == ONES_STUFF)) begin
				// data bit (stuffed zeros are skipped above)
				byte_shift = {b, byte_shift[7:1]};
				bit_pos++;
				if (bit_pos == BITS_PER_BYTE) begin
					bit_pos = '0;
					cap = (max_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : max_len;
					if (byte_cnt >= cap) begin
						len = byte_cnt;
						drop_frame(MODE_HUNT);
						abort_cnt++;
						post_event(EV_OVF_ABORT, 8'h00, len);
					end else begin
						byte_cnt++;
						mode = MODE_DATA;
						post_event(EV_DATA, byte_shift, byte_cnt);
					end
				end
			end
		end
	endtask

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		dec_result_t want;
		if (!arst_n) begin
			line_window = '0;
			ones_len = '0;
			good_cnt = '0;
			abort_cnt = '0;
			min_len = MIN_LEN_RST;
			max_len = MAX_LEN_RST;
			drop_frame(MODE_HUNT);
			expected_events.delete();
			mismatches = 0;
			results_seen = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MIN_LEN)
					min_len = cfg_data;
				else if (cfg_index == REG_MAX_LEN)
					max_len = cfg_data;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_events.size() == 0) begin
					$display("%0t: result with none expected: event %0d, byte %0d, length %0d",
						$time, event_res, data_byte, frame_length);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_res", want.ev, event_res);
					check_field("data_byte", want.data_byte, data_byte);
					check_field("frame_length", want.frame_length, frame_length);
					check_field("good_frame_count", want.good_frames, good_frame_count);
					check_field("abort_count", want.aborts_seen, abort_count);
				end
			end
			if (in_valid && !in_stall)
				deframe_bit(rx_bit, restart);
			pending = expected_events.size();
		end
	end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Top of the HDLC bit deframer test: clock, reset, line-bit stimulus built from
// stuffed frames, receiver stall and verdict. Depends on hdb_pkg,
// hdlc_bit_deframer_unit and hdb_checker.
`default_nettype none

module testbench;
	import hdb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 40;
	localparam int NUM_PHASES  = 7;
	localparam int LONG_HOLD   = 200;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  rx_bit;
	logic                  restart;
	logic                  out_valid;
	logic                  out_stall;
	logic [2:0]            event_res;
	logic [7:0]            data_byte;
	logic [LEN_W-1:0]      frame_length;
	logic [CNT_W-1:0]      good_frame_count;
	logic [CNT_W-1:0]      abort_count;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending;
	int                    results_seen;

	typedef struct packed {
		logic b;
		logic rs;
	} line_item_t;

	line_item_t line_items[$];
	int         tx_ones;
	int         items_sent;
	int         cur_max;

	always #5 clk = ~clk;

	hdlc_bit_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_bit(rx_bit),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.data_byte(data_byte),
		.frame_length(frame_length),
		.good_frame_count(good_frame_count),
		.abort_count(abort_count),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	hdb_checker deframe_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_bit(rx_bit),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.data_byte(data_byte),
		.frame_length(frame_length),
		.good_frame_count(good_frame_count),
		.abort_count(abort_count),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen)
	);

	// Line-bit builders
	function automatic void put_raw(logic b, logic rs);
		line_item_t it;
		it.b = b;
		it.rs = rs;
		line_items.push_back(it);
	endfunction

	function automatic void put_flag();
		for (int i = 0; i < 8; i++)
			put_raw(FLAG_PATTERN[i], 1'b0);
		tx_ones = 0;
	endfunction

	// Data bit with zero insertion after five ones
	function automatic void put_data_bit(logic b);
		put_raw(b, 1'b0);
		if (b) begin
			tx_ones++;
			if (tx_ones == 5) begin
				put_raw(1'b0, 1'b0);
				tx_ones = 0;
			end
		end else begin
			tx_ones = 0;
		end
	endfunction

	function automatic void put_byte(logic [7:0] d);
		for (int i = 0; i < 8; i++)
			put_data_bit(d[i]);
	endfunction

	// One random frame or stretch of line noise
	function automatic void make_frame();
		int         kind;
		int         n;
		logic [7:0] d;
		kind = $urandom_range(0, 9);
		n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 5);
		if (kind == 8) begin
			repeat ($urandom_range(4, 20)) put_raw(1'($urandom_range(0, 1)), 1'b0);
		end else begin
			put_flag();
			if ($urandom_range(0, 3) == 0)
				put_flag();
			if (kind == 9 && cur_max < 8)
				n = cur_max + $urandom_range(1, 3);
			// bytes biased toward runs of ones to exercise stuffing
			repeat (n) begin
				case ($urandom_range(0, 7))
					0: d = 8'hFF;
					1: d = FLAG_PATTERN;
					2: d = 8'hF8;
					default: d = 8'($urandom);
				endcase
				put_byte(d);
			end
			case (kind)
				5: begin
					// closing flag not on a byte boundary
					repeat ($urandom_range(1, 7)) put_data_bit(1'($urandom_range(0, 1)));
					put_flag();
				end
				6: begin
					repeat ($urandom_range(0, 7)) put_data_bit(1'($urandom_range(0, 1)));
					repeat ($urandom_range(7, 10)) put_raw(1'b1, 1'b0);
				end
				7: begin
					repeat ($urandom_range(0, 7)) put_data_bit(1'($urandom_range(0, 1)));
					repeat ($urandom_range(1, 2)) put_raw(1'($urandom_range(0, 1)), 1'b1);
				end
				default: put_flag();
			endcase
		end
	endfunction

	// Send every queued line bit, with a random gap before each item unless sent as a burst
	task automatic send_queued();
		line_item_t it;
		int         gap;
		bit         burst;
		burst = ($urandom_range(0, 3) == 0);
		while (line_items.size() != 0) begin
			it = line_items.pop_front();
			gap = burst ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			rx_bit <= it.b;
			restart <= it.rs;
			do
				@(posedge clk);
			while (in_stall);
			items_sent++;
		end
	endtask

	// Hold off until all predicted results are in and the pipeline has drained
	task automatic wait_idle();
		repeat (4) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_lengths(int min_v, int max_v);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_LEN;
		cfg_data <= CFG_DATA_W'(min_v);
		@(posedge clk);
		cfg_index <= REG_MAX_LEN;
		cfg_data <= CFG_DATA_W'(max_v);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_max = max_v;
	endtask

	// Receiver: random stall after each result, calm stretches, one long hold
	initial begin : receiver
		int stall_left;
		int taken;
		bit calm;
		out_stall <= 1'b0;
		stall_left = 0;
		taken = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				taken++;
				if (taken % 16 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if (taken == 30)
					stall_left = LONG_HOLD;
				else
					stall_left = calm ? 0 : $urandom_range(0, 11);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Run limit
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Stimulus and verdict
	initial begin : stimulus
		int phase_start;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_bit <= 1'b0;
		restart <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		tx_ones = 0;
		items_sent = 0;
		cur_max = int'(MAX_LEN_RST);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: restart, flag, an all-ones byte with a stuffed zero, closing flag
		put_raw(1'b1, 1'b1);
		put_flag();
		put_byte(8'hFF);
		put_flag();
		send_queued();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				in_valid <= 1'b0;
				wait_idle();
				case (p)
					1: set_lengths(0, 0);
					2: set_lengths(1023, 1023);
					3: set_lengths(0, 1023);
					4: set_lengths(3, 5);
					5: set_lengths($urandom_range(0, 8), $urandom_range(1, 10));
					default: set_lengths(int'(MIN_LEN_RST), int'(MAX_LEN_RST));
				endcase
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				make_frame();
				send_queued();
			end
		end
		in_valid <= 1'b0;
		wait_idle();

		$display("tb: %0d line bits over %0d length settings, %0d results checked",
			items_sent, NUM_PHASES, results_seen);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
src/hdb_pkg.sv
src/hdb_step.sv
src/hdlc_bit_deframer_unit.sv
src/hdb_checker.sv
verif/hdb_checker.sv
verif/testbench.sv
